// ===== rtl/baro_temp_pressure_compensation_unit_assert.svh =====
// Assertion macros for the barometer compensation unit.
// Expects clk and rst_n in the scope of use; no other dependencies.
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_UNIT_ASSERT_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_UNIT_ASSERT_SVH

// Same-cycle implication
`define BPC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Plain invariant
`define BPC_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`endif

// ===== rtl/bpc_pkg.sv =====
// Shared types and constants for the barometer compensation unit.
// No dependencies.
`default_nettype none

package bpc_pkg;

    localparam int DivBits    = 64;
    localparam int TempOffset = 128000;
    localparam int PressBase  = 1048576;
    localparam int PressScale = 3125;
    localparam logic [63:0] DivBias = 64'h0000_8000_0000_0000;

    typedef enum logic [2:0] {
        CFG_TEMP_TRIM    = 3'd0,
        CFG_PRESS_TRIM_A = 3'd1,
        CFG_PRESS_TRIM_B = 3'd2,
        CFG_PRESS_TRIM_C = 3'd3
    } cfg_index_t;

    typedef struct packed {
        logic [47:0] temp;
        logic [47:0] press_a;
        logic [47:0] press_b;
        logic [47:0] press_c;
    } trim_t;

    typedef struct packed {
        logic [31:0] tcenti;
        logic [31:0] tfine;
    } temp_t;

    typedef struct packed {
        logic        vld;
        logic [63:0] num;
        logic [63:0] den;
        temp_t       t;
    } div_in_t;

    typedef struct packed {
        logic        vld;
        logic [63:0] quo;
        logic        nz;
        temp_t       t;
    } div_out_t;

endpackage

`default_nettype wire

// ===== rtl/baro_temp_pressure_compensation_unit.sv =====
// Top level of the barometer compensation unit: trim registers and pipeline.
// Depends on bpc_pkg, bpc_front, bpc_div, bpc_back and the assertion header.
//
// Channel  Direction  Handshake              Word
// item     in         item_valid/item_stall  raw_temperature, raw_pressure
// result   out        result_valid/result_stall
//                                            temperature_centi, fine_temperature,
//                                            pressure_q24_8, pressure_valid
// cfg      in         cfg_valid/cfg_ready    cfg_index, cfg_data
//
// One word enters per cycle while the output is not stalled; each passes to the output register
// through 10 front stages, 66 in the bit-per-stage divider and 5 back stages.
// Reset clears the trim registers and every stage valid bit.
// A stalled output freezes the whole pipeline; item_stall follows at once.
`default_nettype none
`include "baro_temp_pressure_compensation_unit_assert.svh"

module baro_temp_pressure_compensation_unit import bpc_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic [19:0]        raw_temperature,
    input  logic [19:0]        raw_pressure,
    output logic               result_valid,
    input  logic               result_stall,
    output logic signed [31:0] temperature_centi,
    output logic signed [31:0] fine_temperature,
    output logic [31:0]        pressure_q24_8,
    output logic               pressure_valid,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [47:0]        cfg_data
);

    trim_t    trim_reg;
    logic     adv;
    div_in_t  div_in;
    div_out_t div_out;

    assign adv        = !result_valid || !result_stall;
    assign item_stall = !adv;
    assign cfg_ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trim_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TEMP_TRIM:    trim_reg.temp    <= cfg_data;
                CFG_PRESS_TRIM_A: trim_reg.press_a <= cfg_data;
                CFG_PRESS_TRIM_B: trim_reg.press_b <= cfg_data;
                CFG_PRESS_TRIM_C: trim_reg.press_c <= cfg_data;
                default:          ;
            endcase
        end
    end

    bpc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .item_vld (item_valid),
        .raw_t    (raw_temperature),
        .raw_p    (raw_pressure),
        .trim     (trim_reg),
        .dout     (div_in)
    );

    bpc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .din   (div_in),
        .dout  (div_out)
    );

    bpc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .din      (div_out),
        .press_c  (trim_reg.press_c),
        .out_vld  (result_valid),
        .tcenti   (temperature_centi),
        .tfine    (fine_temperature),
        .press    (pressure_q24_8),
        .press_ok (pressure_valid)
    );

    `BPC_ASSERT_NOW(a_zero_press, result_valid && !pressure_valid, pressure_q24_8 == 32'b0, "pressure not zero on zero divisor")
    `BPC_ASSERT_NOW(a_stall_src, item_stall, result_valid && result_stall, "input stalled without a held word")
    `BPC_ASSERT_ALWAYS(a_temp_align, !result_valid || temperature_centi == ((fine_temperature * 32'sd5 + 32'sd128) >>> 8), "temperature fields misaligned")

endmodule

`default_nettype wire

// ===== rtl/bpc_front.sv =====
// Temperature path and pressure coefficient stages (ten register stages).
// Depends on bpc_pkg.
`default_nettype none

module bpc_front import bpc_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  logic        item_vld,
    input  logic [19:0] raw_t,
    input  logic [19:0] raw_p,
    input  trim_t       trim,
    output div_in_t     dout
);

    logic [31:0]        t1;
    logic signed [15:0] t2, t3;
    logic [15:0]        p1;
    logic signed [15:0] p2, p3, p4, p5, p6;

    assign t1 = {16'b0, trim.temp[15:0]};
    assign t2 = trim.temp[31:16];
    assign t3 = trim.temp[47:32];
    assign p1 = trim.press_a[15:0];
    assign p2 = trim.press_a[31:16];
    assign p3 = trim.press_a[47:32];
    assign p4 = trim.press_b[15:0];
    assign p5 = trim.press_b[31:16];
    assign p6 = trim.press_b[47:32];

    logic [9:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[8:0], item_vld};
        end
    end

    // stage 1
    logic [31:0]        s1_x, s1_d;
    logic signed [47:0] s1_prod;
    logic [31:0]        s1_a_reg, s1_dd_reg;
    logic [19:0]        s1_p_reg;

    always_comb
    begin
        s1_x    = {15'b0, raw_t[19:3]} - (t1 << 1);
        s1_prod = $signed(s1_x) * t2;
        s1_d    = {16'b0, raw_t[19:4]} - t1;
    end

    // stage 2
    logic signed [31:0] s2_sh;
    logic signed [47:0] s2_prod;
    logic signed [31:0] s2_v1_reg;
    logic [31:0]        s2_m_reg;
    logic [19:0]        s2_p_reg;

    always_comb
    begin
        s2_sh   = $signed(s1_dd_reg) >>> 12;
        s2_prod = s2_sh * t3;
    end

    // stage 3
    logic signed [31:0] s3_tf_reg;
    logic [19:0]        s3_p_reg;

    // stage 4
    logic signed [31:0] s4_mul;
    logic signed [33:0] s4_w_reg;
    temp_t              s4_t_reg;
    logic [19:0]        s4_p_reg;

    always_comb
    begin
        s4_mul = s3_tf_reg * 32'sd5 + 32'sd128;
    end

    // stage 5
    logic [33:0]        s5_abs;
    logic [63:0]        s5_sq_reg;
    logic signed [49:0] s5_wp5_reg, s5_wp2_reg;
    temp_t              s5_t_reg;
    logic [19:0]        s5_p_reg;

    always_comb
    begin
        s5_abs = s4_w_reg[33] ? 34'(-s4_w_reg) : s4_w_reg;
    end

    // stage 6
    logic signed [48:0] s6_l6_reg, s6_l3_reg;
    logic [31:0]        s6_h6_reg, s6_h3_reg;
    logic signed [49:0] s6_wp5_reg, s6_wp2_reg;
    temp_t              s6_t_reg;
    logic [19:0]        s6_p_reg;

    // stage 7
    logic signed [63:0] s7_c3;
    logic [63:0]        s7_w2_reg;
    logic signed [63:0] s7_x_reg;
    temp_t              s7_t_reg;
    logic [19:0]        s7_p_reg;

    always_comb
    begin
        s7_c3 = 64'(s6_l3_reg) + {s6_h3_reg, 32'b0};
    end

    // stage 8
    logic [20:0]        s8_pr;
    logic [63:0]        s8_y_reg, s8_n_reg;
    temp_t              s8_t_reg;

    always_comb
    begin
        s8_pr = 21'(PressBase) - {1'b0, s7_p_reg};
    end

    // stage 9
    logic [47:0]        s9_yl_reg;
    logic [31:0]        s9_yh_reg, s9_nh_reg;
    logic [43:0]        s9_nl_reg;
    temp_t              s9_t_reg;

    // stage 10
    logic [63:0]        s10_dp;
    logic [63:0]        s10_den_reg, s10_num_reg;
    temp_t              s10_t_reg;

    always_comb
    begin
        s10_dp = 64'(s9_yl_reg) + {s9_yh_reg, 32'b0};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_a_reg   <= s1_prod[31:0];
            s1_dd_reg  <= s1_d * s1_d;
            s1_p_reg   <= raw_p;

            s2_v1_reg  <= $signed(s1_a_reg) >>> 11;
            s2_m_reg   <= s2_prod[31:0];
            s2_p_reg   <= s1_p_reg;

            s3_tf_reg  <= s2_v1_reg + ($signed(s2_m_reg) >>> 14);
            s3_p_reg   <= s2_p_reg;

            s4_w_reg        <= 34'(s3_tf_reg) - 34'(TempOffset);
            s4_t_reg.tcenti <= s4_mul >>> 8;
            s4_t_reg.tfine  <= s3_tf_reg;
            s4_p_reg        <= s3_p_reg;

            s5_sq_reg  <= s5_abs[31:0] * s5_abs[31:0];
            s5_wp5_reg <= s4_w_reg * p5;
            s5_wp2_reg <= s4_w_reg * p2;
            s5_t_reg   <= s4_t_reg;
            s5_p_reg   <= s4_p_reg;

            // split the 64-bit square into 32-bit halves so each multiply takes one half
            s6_l6_reg  <= $signed({1'b0, s5_sq_reg[31:0]}) * p6;
            s6_l3_reg  <= $signed({1'b0, s5_sq_reg[31:0]}) * p3;
            s6_h6_reg  <= s5_sq_reg[63:32] * 32'(p6);
            s6_h3_reg  <= s5_sq_reg[63:32] * 32'(p3);
            s6_wp5_reg <= s5_wp5_reg;
            s6_wp2_reg <= s5_wp2_reg;
            s6_t_reg   <= s5_t_reg;
            s6_p_reg   <= s5_p_reg;

            s7_w2_reg  <= 64'(s6_l6_reg) + {s6_h6_reg, 32'b0}
                          + (64'(s6_wp5_reg) << 17) + (64'(p4) << 35);
            s7_x_reg   <= (s7_c3 >>> 8) + (64'(s6_wp2_reg) << 12);
            s7_t_reg   <= s6_t_reg;
            s7_p_reg   <= s6_p_reg;

            s8_y_reg   <= DivBias + s7_x_reg;
            s8_n_reg   <= (64'(s8_pr) << 31) - s7_w2_reg;
            s8_t_reg   <= s7_t_reg;

            s9_yl_reg  <= s8_y_reg[31:0] * p1;
            s9_yh_reg  <= s8_y_reg[63:32] * 32'(p1);
            s9_nl_reg  <= s8_n_reg[31:0] * 12'(PressScale);
            s9_nh_reg  <= s8_n_reg[63:32] * 32'(PressScale);
            s9_t_reg   <= s8_t_reg;

            s10_den_reg <= $signed(s10_dp) >>> 33;
            s10_num_reg <= 64'(s9_nl_reg) + {s9_nh_reg, 32'b0};
            s10_t_reg   <= s9_t_reg;
        end
    end

    assign dout.vld = vld_reg[9];
    assign dout.num = s10_num_reg;
    assign dout.den = s10_den_reg;
    assign dout.t   = s10_t_reg;

endmodule

`default_nettype wire

// ===== rtl/bpc_div.sv =====
// Pipelined signed 64-bit divider, one quotient bit per stage.
// Depends on bpc_pkg.
`default_nettype none

module bpc_div import bpc_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     adv,
    input  div_in_t  din,
    output div_out_t dout
);

    typedef struct packed {
        logic [63:0] r;
        logic [63:0] q;
        logic [63:0] mb;
        logic        neg;
        logic        nz;
        temp_t       t;
    } dstage_t;

    logic [DivBits+1:0] vld_reg;
    dstage_t            st_reg [0:DivBits];
    logic [63:0]        quo_reg;
    logic               nz_reg;
    temp_t              t_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[DivBits:0], din.vld};
        end
    end

    // take magnitudes; sign of quotient rides along
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_reg[0].r   <= '0;
            st_reg[0].q   <= din.num[63] ? 64'(0) - din.num : din.num;
            st_reg[0].mb  <= din.den[63] ? 64'(0) - din.den : din.den;
            st_reg[0].neg <= din.num[63] ^ din.den[63];
            st_reg[0].nz  <= din.den != '0;
            st_reg[0].t   <= din.t;
        end
    end

    for (genvar i = 0; i < DivBits; i++)
    begin : g_step
        logic [64:0] trial, diff;
        logic        take;
        dstage_t     step_next;

        always_comb
        begin
            trial = {st_reg[i].r, st_reg[i].q[63]};
            diff  = trial - {1'b0, st_reg[i].mb};
            take  = trial >= {1'b0, st_reg[i].mb};
            step_next     = st_reg[i];
            step_next.r   = take ? diff[63:0] : trial[63:0];
            step_next.q   = {st_reg[i].q[62:0], take};
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                st_reg[i+1] <= step_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            quo_reg <= st_reg[DivBits].neg ? 64'(0) - st_reg[DivBits].q
                                           : st_reg[DivBits].q;
            nz_reg  <= st_reg[DivBits].nz;
            t_reg   <= st_reg[DivBits].t;
        end
    end

    assign dout.vld = vld_reg[DivBits+1];
    assign dout.quo = quo_reg;
    assign dout.nz  = nz_reg;
    assign dout.t   = t_reg;

endmodule

`default_nettype wire

// ===== rtl/bpc_back.sv =====
// Pressure correction after the division, ending in the output register.
// Depends on bpc_pkg.
`default_nettype none

module bpc_back import bpc_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  div_out_t           din,
    input  logic [47:0]        press_c,
    output logic               out_vld,
    output logic signed [31:0] tcenti,
    output logic signed [31:0] tfine,
    output logic [31:0]        press,
    output logic               press_ok
);

    logic signed [15:0] p7, p8, p9;

    assign p7 = press_c[15:0];
    assign p8 = press_c[31:16];
    assign p9 = press_c[47:32];

    logic [4:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[3:0], din.vld};
        end
    end

    logic signed [63:0] b1_ph;
    logic signed [63:0] b1_p_reg;
    logic [63:0]        b1_ll_reg;
    logic [31:0]        b1_lh_reg, b1_h8_reg;
    logic signed [48:0] b1_l8_reg;
    logic               b1_nz_reg;
    temp_t              b1_t_reg;

    always_comb
    begin
        b1_ph = $signed(din.quo) >>> 13;
    end

    logic signed [63:0] b2_c8;
    logic signed [63:0] b2_p_reg, b2_x2_reg;
    logic [63:0]        b2_sq_reg;
    logic               b2_nz_reg;
    temp_t              b2_t_reg;

    always_comb
    begin
        b2_c8 = 64'(b1_l8_reg) + {b1_h8_reg, 32'b0};
    end

    logic signed [63:0] b3_p_reg, b3_x2_reg;
    logic signed [48:0] b3_l9_reg;
    logic [31:0]        b3_h9_reg;
    logic               b3_nz_reg;
    temp_t              b3_t_reg;

    logic signed [63:0] b4_c9;
    logic signed [63:0] b4_p_reg, b4_x2_reg, b4_x1_reg;
    logic               b4_nz_reg;
    temp_t              b4_t_reg;

    always_comb
    begin
        b4_c9 = 64'(b3_l9_reg) + {b3_h9_reg, 32'b0};
    end

    logic signed [63:0] b5_sum, b5_press;
    logic [31:0]        press_reg;
    logic               ok_reg;
    temp_t              t_reg;

    always_comb
    begin
        b5_sum   = b4_p_reg + b4_x1_reg + b4_x2_reg;
        b5_press = (b5_sum >>> 8) + (64'(p7) << 4);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // square of p >> 13, low 64 bits from 32-bit pieces
            b1_p_reg  <= din.quo;
            b1_ll_reg <= b1_ph[31:0] * b1_ph[31:0];
            b1_lh_reg <= b1_ph[31:0] * b1_ph[63:32];
            b1_l8_reg <= $signed({1'b0, din.quo[31:0]}) * p8;
            b1_h8_reg <= din.quo[63:32] * 32'(p8);
            b1_nz_reg <= din.nz;
            b1_t_reg  <= din.t;

            b2_p_reg  <= b1_p_reg;
            b2_sq_reg <= b1_ll_reg + {b1_lh_reg[30:0], 33'b0};
            b2_x2_reg <= b2_c8 >>> 19;
            b2_nz_reg <= b1_nz_reg;
            b2_t_reg  <= b1_t_reg;

            b3_p_reg  <= b2_p_reg;
            b3_x2_reg <= b2_x2_reg;
            b3_l9_reg <= $signed({1'b0, b2_sq_reg[31:0]}) * p9;
            b3_h9_reg <= b2_sq_reg[63:32] * 32'(p9);
            b3_nz_reg <= b2_nz_reg;
            b3_t_reg  <= b2_t_reg;

            b4_p_reg  <= b3_p_reg;
            b4_x2_reg <= b3_x2_reg;
            b4_x1_reg <= b4_c9 >>> 25;
            b4_nz_reg <= b3_nz_reg;
            b4_t_reg  <= b3_t_reg;

            // zero divisor: force pressure to zero
            press_reg <= b4_nz_reg ? b5_press[31:0] : 32'b0;
            ok_reg    <= b4_nz_reg;
            t_reg     <= b4_t_reg;
        end
    end

    assign out_vld  = vld_reg[4];
    assign tcenti   = t_reg.tcenti;
    assign tfine    = t_reg.tfine;
    assign press    = press_reg;
    assign press_ok = ok_reg;

endmodule

`default_nettype wire

// ===== tb/sv/baro_temp_pressure_compensation_unit_checker.sv =====
// Checker for the barometer compensation unit: tracks trim writes, predicts each result word.
// It compares every accepted result with the oldest prediction.
// Depends on bpc_pkg.
`timescale 1ns / 1ps

module baro_temp_pressure_compensation_unit_checker import bpc_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  logic        item_stall,
    input  logic [19:0] raw_temperature,
    input  logic [19:0] raw_pressure,
    input  logic        result_valid,
    input  logic        result_stall,
    input  logic [31:0] temperature_centi,
    input  logic [31:0] fine_temperature,
    input  logic [31:0] pressure_q24_8,
    input  logic        pressure_valid,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data,
    output int          outstanding,
    output int          mismatches
);

    typedef struct packed {
        bit [31:0] tcenti;
        bit [31:0] tfine;
        bit [31:0] press;
        bit        press_ok;
    } reading_t;

    reading_t  expected_readings[$];
    bit [47:0] trim_temp, trim_pa, trim_pb, trim_pc;

    function automatic bit [31:0] sra32(input bit [31:0] x, input int n);
        return $signed(x) >>> n;
    endfunction

    function automatic bit [63:0] sra64(input bit [63:0] x, input int n);
        return $signed(x) >>> n;
    endfunction

    function automatic bit [63:0] sext16(input bit [15:0] w);
        return {{48{w[15]}}, w};
    endfunction

    // Signed divide, truncating; the most negative value over -1 wraps
    function automatic bit [63:0] quot64(input bit [63:0] n, input bit [63:0] d);
        bit [63:0] mn, md, q;
        mn = n[63] ? -n : n;
        md = d[63] ? -d : d;
        q  = mn / md;
        return (n[63] != d[63]) ? -q : q;
    endfunction

    function automatic reading_t compensate(input bit [19:0] rt, input bit [19:0] rp);
        reading_t  r;
        bit [31:0] adc_t, t1, t2, t3, prod, v1, d, v2, tfine;
        bit [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        bit [63:0] w1, w2, p, ph, x1, x2;
        adc_t = {12'd0, rt};
        t1    = {16'd0, trim_temp[15:0]};
        t2    = 32'(sext16(trim_temp[31:16]));
        t3    = 32'(sext16(trim_temp[47:32]));
        prod  = ((adc_t >> 3) - (t1 << 1)) * t2;
        v1    = sra32(prod, 11);
        d     = (adc_t >> 4) - t1;
        prod  = sra32(d * d, 12) * t3;
        v2    = sra32(prod, 14);
        tfine = v1 + v2;
        r.tfine  = tfine;
        r.tcenti = sra32(tfine * 32'd5 + 32'd128, 8);

        p1 = {48'd0, trim_pa[15:0]};
        p2 = sext16(trim_pa[31:16]);
        p3 = sext16(trim_pa[47:32]);
        p4 = sext16(trim_pb[15:0]);
        p5 = sext16(trim_pb[31:16]);
        p6 = sext16(trim_pb[47:32]);
        p7 = sext16(trim_pc[15:0]);
        p8 = sext16(trim_pc[31:16]);
        p9 = sext16(trim_pc[47:32]);

        w1 = {{32{tfine[31]}}, tfine} - 64'd128000;
        w2 = w1 * w1 * p6 + ((w1 * p5) << 17) + (p4 << 35);
        w1 = sra64(w1 * w1 * p3, 8) + ((w1 * p2) << 12);
        w1 = sra64(((64'd1 << 47) + w1) * p1, 33);
        r.press    = '0;
        r.press_ok = 1'b0;
        if (w1 != 0) begin
            p  = 64'd1048576 - {44'd0, rp};
            p  = quot64(((p << 31) - w2) * 64'd3125, w1);
            ph = sra64(p, 13);
            x1 = sra64(p9 * ph * ph, 25);
            x2 = sra64(p8 * p, 19);
            p  = sra64(p + x1 + x2, 8) + (p7 << 4);
            r.press    = p[31:0];
            r.press_ok = 1'b1;
        end
        return r;
    endfunction

    assign outstanding = expected_readings.size();

    always @(posedge clk or negedge rst_n)
    begin
        reading_t want;
        int       errs;
        if (!rst_n) begin
            trim_temp  <= '0;
            trim_pa    <= '0;
            trim_pb    <= '0;
            trim_pc    <= '0;
            mismatches <= 0;
            expected_readings.delete();
        end else begin
            errs = 0;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_TEMP_TRIM:    trim_temp <= cfg_data;
                    CFG_PRESS_TRIM_A: trim_pa   <= cfg_data;
                    CFG_PRESS_TRIM_B: trim_pb   <= cfg_data;
                    CFG_PRESS_TRIM_C: trim_pc   <= cfg_data;
                    default: ;
                endcase
            end
            if (item_valid && !item_stall)
                expected_readings.push_back(compensate(raw_temperature, raw_pressure));
            if (result_valid && !result_stall) begin
                if (expected_readings.size() == 0) begin
                    $error("unexpected result word");
                    errs++;
                end else begin
                    want = expected_readings.pop_front();
                    if (temperature_centi !== want.tcenti) begin
                        $error("temperature_centi: expected %0d, got %0d",
                               $signed(want.tcenti), $signed(temperature_centi));
                        errs++;
                    end
                    if (fine_temperature !== want.tfine) begin
                        $error("fine_temperature: expected %0d, got %0d",
                               $signed(want.tfine), $signed(fine_temperature));
                        errs++;
                    end
                    if (pressure_q24_8 !== want.press) begin
                        $error("pressure_q24_8: expected %0d, got %0d",
                               want.press, pressure_q24_8);
                        errs++;
                    end
                    if (pressure_valid !== want.press_ok) begin
                        $error("pressure_valid: expected %0d, got %0d",
                               want.press_ok, pressure_valid);
                        errs++;
                    end
                end
            end
            mismatches <= mismatches + errs;
        end
    end

endmodule

// ===== tb/sv/baro_temp_pressure_compensation_unit_tb.sv =====
// Top of the barometer compensation unit testbench: clock, reset, stimulus, verdict.
// Depends on bpc_pkg, the unit and its checker.
`timescale 1ns / 1ps

module baro_temp_pressure_compensation_unit_tb;
    import bpc_pkg::*;

    localparam int          PipeDepth   = 81;
    localparam logic [2:0]  CfgUnusedIdx = 3'd6;

    logic        clk, rst_n;
    logic        item_valid, item_stall;
    logic [19:0] raw_temperature, raw_pressure;
    logic        result_valid, result_stall;
    logic [31:0] temperature_centi, fine_temperature, pressure_q24_8;
    logic        pressure_valid;
    logic        cfg_valid, cfg_ready;
    logic [2:0]  cfg_index;
    logic [47:0] cfg_data;
    int          outstanding, mismatches;
    bit          gaps_on;

    baro_temp_pressure_compensation_unit dut (.*);
    baro_temp_pressure_compensation_unit_checker chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Sink: draw a hold-off per result word, then take it
    initial
    begin
        int n;
        result_stall = 1'b1;
        @(posedge rst_n);
        forever begin
            n = gaps_on ? $urandom_range(0, 14) : 0;
            if (n > 0) begin
                result_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            result_stall <= 1'b0;
            do @(negedge clk); while (!result_valid);
            @(posedge clk);
        end
    end

    task automatic send_reading(input logic [19:0] rt, input logic [19:0] rp);
        int n;
        n = gaps_on ? $urandom_range(0, 14) : 0;
        if (n > 0) begin
            item_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        item_valid      <= 1'b1;
        raw_temperature <= rt;
        raw_pressure    <= rp;
        do @(negedge clk); while (item_stall);
        @(posedge clk);
    endtask

    task automatic drain();
        if (item_valid) item_valid <= 1'b0;
        while (outstanding != 0) @(posedge clk);
        repeat (PipeDepth + 10) @(posedge clk);
    endtask

    task automatic write_trim(input logic [2:0] idx, input logic [47:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_trims(input logic [47:0] t, a, b, c);
        write_trim(CFG_TEMP_TRIM, t);
        write_trim(CFG_PRESS_TRIM_A, a);
        write_trim(CFG_PRESS_TRIM_B, b);
        write_trim(CFG_PRESS_TRIM_C, c);
    endtask

    task automatic random_readings(input int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) == 0) gaps_on = ~gaps_on;
            if ($urandom_range(0, 3) == 0)
                send_reading(20'($urandom), 20'($urandom));
            else
                send_reading(20'(400000 + $urandom_range(0, 250000)),
                             20'(250000 + $urandom_range(0, 400000)));
        end
    endtask

    function automatic logic [47:0] rand48();
        return 48'({$urandom, $urandom});
    endfunction

    initial
    begin
        logic [47:0] typ_t, typ_a, typ_b, typ_c;
        typ_t = {16'hFC18, 16'd26435, 16'd27504};
        typ_a = {16'd3024, 16'hD643, 16'd36477};
        typ_b = {16'hFFF9, 16'd140, 16'd2855};
        typ_c = {16'd6000, 16'hC6F8, 16'd15500};
        gaps_on         = 1'b1;
        rst_n           = 1'b0;
        item_valid      = 1'b0;
        raw_temperature = '0;
        raw_pressure    = '0;
        cfg_valid       = 1'b0;
        cfg_index       = CFG_TEMP_TRIM;
        cfg_data        = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset trims: divisor is zero, pressure forced to zero
        send_reading(20'd0, 20'd0);
        send_reading(20'hFFFFF, 20'hFFFFF);
        send_reading(20'd519888, 20'd415148);
        drain();

        load_trims(typ_t, typ_a, typ_b, typ_c);
        write_trim(CfgUnusedIdx, '1);
        send_reading(20'd0, 20'd0);
        send_reading(20'hFFFFF, 20'd0);
        send_reading(20'd0, 20'hFFFFF);
        send_reading(20'hFFFFF, 20'hFFFFF);
        send_reading(20'd519888, 20'd415148);
        send_reading(20'h55555, 20'hAAAAA);
        send_reading(20'hAAAAA, 20'h55555);
        drain();

        // Zero P1 leaves no divisor; all-ones trims drive extremes
        load_trims(typ_t, {typ_a[47:16], 16'd0}, typ_b, typ_c);
        send_reading(20'd519888, 20'd415148);
        send_reading(20'hFFFFF, 20'd0);
        drain();
        load_trims('1, '1, '1, '1);
        send_reading(20'd0, 20'd0);
        send_reading(20'hFFFFF, 20'hFFFFF);
        send_reading(20'd519888, 20'd415148);
        drain();
        load_trims({16'h7FFF, 16'h8000, 16'hFFFF}, {16'h8000, 16'h7FFF, 16'hFFFF},
                   {16'h7FFF, 16'h8000, 16'h7FFF}, {16'h8000, 16'h7FFF, 16'h8000});
        send_reading(20'd0, 20'hFFFFF);
        send_reading(20'hFFFFF, 20'd0);
        drain();

        load_trims(typ_t, typ_a, typ_b, typ_c);
        random_readings(500);
        drain();
        for (int ph = 0; ph < 5; ph++) begin
            if (ph == 0)
                load_trims(rand48(), rand48(), rand48(), rand48());
            else
                load_trims({rand48() | 48'h0000_0000_8000} & typ_t | (rand48() & 48'h00FF_00FF_0FFF),
                           typ_a ^ (rand48() & 48'h00FF_00FF_0FFF),
                           typ_b ^ (rand48() & 48'h000F_00FF_03FF),
                           typ_c ^ (rand48() & 48'h03FF_03FF_03FF));
            random_readings(150);
            drain();
        end

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
